### rtl/tksel_pkg.sv
// ----------------------------------------------------------------------------
// tksel_pkg
// shared types and constants of the top-k threshold selector
// ----------------------------------------------------------------------------
package tksel_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int LIST_LIMIT  = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;
  localparam int IDX_W       = (LIST_LIMIT > 1) ? $clog2(LIST_LIMIT) : 1;
  localparam int CNT_W       = $clog2(LIST_LIMIT + 1);

  localparam int SCORE_W = 32;
  localparam int TAG_W   = 16;
  localparam int RANK_W  = 4;
  localparam int KEEP_W  = 5;
  localparam int CFG_W   = 5;

  localparam logic signed [SCORE_W-1:0] MOST_NEG   = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic [KEEP_W-1:0]         KEEP_RESET = KEEP_W'(8);

  typedef enum logic {
    REG_KEEP_COUNT    = 1'b0,
    REG_USE_THRESHOLD = 1'b1
  } reg_index_t;

  typedef enum logic {
    KIND_OFFER = 1'b0,
    KIND_CLOSE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFER,
    ST_CLOSE,
    ST_EMIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic offer;
    logic close;
    logic shift;
    logic emit;
    logic result;
  } tksel_cmd_t;

  typedef struct packed {
    logic is_close;
    logic empty;
    logic last_entry;
  } tksel_sts_t;

endpackage

### rtl/top_k_threshold_selector_core.sv
// ----------------------------------------------------------------------------
// top_k_threshold_selector_core
// keeps the best scored items of an iteration in a sorted list
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): kind 0 offers score/item_tag, kind 1
// closes the iteration. output channel (out_valid/out_ready) returns one
// beat per offer (accepted), and one beat per kept entry in rank order on a
// close, or a single empty beat when the list is empty. last_of_run marks
// the final beat of each input.
// an offer runs as accept, then the parallel compare-and-shift over all
// list cells, then the result beat; the next input is taken the cycle
// after that beat goes out. a close emits one beat per kept entry in
// rank order, one per cycle while out_ready is high, paced by the list
// shifting up one cell per emitted beat.
// in_ready is low while a result is pending; a stalled receiver holds the
// block with its result steady. reset empties the list, sets threshold and
// best score to the most negative value, keep_count to 8 and threshold
// mode off. cfg_we writes keep_count (index 0) or use_threshold (index 1).
// ----------------------------------------------------------------------------
module top_k_threshold_selector_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [tksel_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic signed [tksel_pkg::SCORE_W-1:0] score,
  input  logic [tksel_pkg::TAG_W-1:0]          item_tag,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 accepted,
  output logic                                 entry_valid,
  output logic signed [tksel_pkg::SCORE_W-1:0] entry_score,
  output logic [tksel_pkg::TAG_W-1:0]          entry_tag,
  output logic [tksel_pkg::RANK_W-1:0]         entry_rank,
  output logic                                 last_of_run,
  output logic signed [tksel_pkg::SCORE_W-1:0] best_score,
  output logic [tksel_pkg::TAG_W-1:0]          best_tag,
  output logic                                 best_changed,
  output logic signed [tksel_pkg::SCORE_W-1:0] threshold_score
);
  import tksel_pkg::*;

  tksel_cmd_t cmd;
  tksel_sts_t sts;

  tksel_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tksel_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .score           (score),
    .item_tag        (item_tag),
    .cmd             (cmd),
    .sts             (sts),
    .accepted        (accepted),
    .entry_valid     (entry_valid),
    .entry_score     (entry_score),
    .entry_tag       (entry_tag),
    .entry_rank      (entry_rank),
    .last_of_run     (last_of_run),
    .best_score      (best_score),
    .best_tag        (best_tag),
    .best_changed    (best_changed),
    .threshold_score (threshold_score)
  );

endmodule

### rtl/tksel_ctrl.sv
// ----------------------------------------------------------------------------
// tksel_ctrl
// sequencer: takes one beat, runs the offer or close, hands out the results
// ----------------------------------------------------------------------------
module tksel_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tksel_pkg::tksel_cmd_t cmd,
  input  tksel_pkg::tksel_sts_t sts
);
  import tksel_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = sts.is_close ? ST_CLOSE : ST_OFFER;
        end
      end
      ST_OFFER: begin
        state_next = ST_RESULT;
      end
      ST_CLOSE: begin
        state_next = sts.empty ? ST_RESULT : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && sts.last_entry) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    out_valid  = (state == ST_EMIT) || (state == ST_RESULT);
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.offer  = (state == ST_OFFER);
    cmd.close  = (state == ST_CLOSE);
    cmd.shift  = (state == ST_EMIT) && out_ready;
    cmd.emit   = (state == ST_EMIT);
    cmd.result = (state == ST_RESULT);
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_offer_path: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !sts.is_close) |=> (state == ST_OFFER))
    else $error("offer beat did not start an offer");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_ready && sts.last_entry) |=> (state == ST_IDLE) && sts.empty)
    else $error("close run did not end with an empty list");

endmodule

### rtl/tksel_datapath.sv
// ----------------------------------------------------------------------------
// tksel_datapath
// sorted list cells with parallel compare and shift, threshold and best score
// ----------------------------------------------------------------------------
module tksel_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [tksel_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 kind,
  input  logic signed [tksel_pkg::SCORE_W-1:0] score,
  input  logic [tksel_pkg::TAG_W-1:0]          item_tag,
  input  tksel_pkg::tksel_cmd_t                cmd,
  output tksel_pkg::tksel_sts_t                sts,
  output logic                                 accepted,
  output logic                                 entry_valid,
  output logic signed [tksel_pkg::SCORE_W-1:0] entry_score,
  output logic [tksel_pkg::TAG_W-1:0]          entry_tag,
  output logic [tksel_pkg::RANK_W-1:0]         entry_rank,
  output logic                                 last_of_run,
  output logic signed [tksel_pkg::SCORE_W-1:0] best_score,
  output logic [tksel_pkg::TAG_W-1:0]          best_tag,
  output logic                                 best_changed,
  output logic signed [tksel_pkg::SCORE_W-1:0] threshold_score
);
  import tksel_pkg::*;

  logic signed [SCORE_W-1:0] ks [LIST_LIMIT];
  logic [TAG_W-1:0]          kt [LIST_LIMIT];
  logic [CNT_W-1:0]          count;
  logic signed [SCORE_W-1:0] thr;
  logic signed [SCORE_W-1:0] best_v;
  logic [TAG_W-1:0]          best_t;
  logic                      changed;
  logic                      acc;
  logic [IDX_W-1:0]          rank;
  logic [KEEP_W-1:0]         keep;
  logic                      use_thr;
  logic                      in_kind;
  logic signed [SCORE_W-1:0] in_score;
  logic [TAG_W-1:0]          in_tag;

  logic [CNT_W-1:0]          cap;
  logic [CNT_W-1:0]          count_m1;
  logic [CNT_W-1:0]          n_eff;
  logic [CNT_W-1:0]          pos;
  logic [CNT_W-1:0]          rank_p1;
  logic [LIST_LIMIT-1:0]     gt;
  logic [LIST_LIMIT-1:0]     ge;
  logic                      full;
  logic                      low_gt;
  logic                      ok;
  logic signed [SCORE_W-1:0] low_score;
  logic                      improve;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keep    <= KEEP_RESET;
      use_thr <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEEP_COUNT:    keep    <= cfg_data[KEEP_W-1:0];
        REG_USE_THRESHOLD: use_thr <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_kind  <= kind;
      in_score <= score;
      in_tag   <= item_tag;
    end
  end

  always_comb begin
    if (keep == '0) begin
      cap = CNT_W'(1);
    end else if (keep > KEEP_W'(LIST_LIMIT)) begin
      cap = CNT_W'(LIST_LIMIT);
    end else begin
      cap = keep[CNT_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < LIST_LIMIT; i++) begin
      gt[i] = in_score > ks[i];
      ge[i] = in_score >= ks[i];
    end
  end

  assign count_m1  = count - 1'b1;
  assign full      = count >= cap;
  assign low_gt    = (count != '0) && gt[count_m1[IDX_W-1:0]];
  assign low_score = ks[count_m1[IDX_W-1:0]];
  assign ok        = (!full || low_gt) && (!use_thr || (in_score > thr));
  assign n_eff     = full ? (cap - 1'b1) : count;
  assign improve   = ks[0] > best_v;
  assign rank_p1   = CNT_W'(rank) + 1'b1;

  // insertion point: first entry the new score meets or beats
  always_comb begin
    pos = n_eff;
    for (int i = LIST_LIMIT - 1; i >= 0; i--) begin
      if (ge[i] && (CNT_W'(i) < n_eff)) begin
        pos = CNT_W'(i);
      end
    end
  end

  for (genvar g = 0; g < LIST_LIMIT; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.offer && ok) begin
        if (CNT_W'(g) == pos) begin
          ks[g] <= in_score;
          kt[g] <= in_tag;
        end else if (g > 0 && CNT_W'(g) > pos && CNT_W'(g) <= n_eff) begin
          ks[g] <= ks[(g > 0) ? g - 1 : 0];
          kt[g] <= kt[(g > 0) ? g - 1 : 0];
        end
      end else if (cmd.shift && g < LIST_LIMIT - 1) begin
        ks[g] <= ks[(g < LIST_LIMIT - 1) ? g + 1 : g];
        kt[g] <= kt[(g < LIST_LIMIT - 1) ? g + 1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      thr    <= MOST_NEG;
      best_v <= MOST_NEG;
      best_t <= '0;
    end else if (cmd.offer) begin
      if (ok) begin
        count <= n_eff + 1'b1;
      end
    end else if (cmd.close) begin
      if (count != '0) begin
        if (use_thr) begin
          thr <= low_score;
        end
        if (improve) begin
          best_v <= ks[0];
          best_t <= kt[0];
        end
      end
    end else if (cmd.shift && sts.last_entry) begin
      count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.offer) begin
      acc <= ok;
    end else if (cmd.close) begin
      acc     <= 1'b0;
      changed <= (count != '0) && improve;
      rank    <= '0;
    end else if (cmd.shift) begin
      rank <= rank_p1[IDX_W-1:0];
    end
  end

  always_comb begin
    sts.is_close   = (kind == KIND_CLOSE);
    sts.empty      = (count == '0);
    sts.last_entry = (rank_p1 == count);
  end

  always_comb begin
    accepted        = cmd.result && acc;
    entry_valid     = cmd.emit;
    entry_score     = cmd.emit ? ks[0] : '0;
    entry_tag       = cmd.emit ? kt[0] : '0;
    entry_rank      = cmd.emit ? RANK_W'(rank) : '0;
    last_of_run     = cmd.result || sts.last_entry;
    best_score      = best_v;
    best_tag        = best_t;
    best_changed    = cmd.emit && changed;
    threshold_score = thr;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LIST_LIMIT))
    else $error("list count beyond its storage");

  a_thr_mode: assert property (@(posedge clk) disable iff (rst)
    (cmd.close && !use_thr) |=> $stable(thr))
    else $error("threshold moved with threshold mode off");

  a_kind_held: assert property (@(posedge clk) disable iff (rst)
    cmd.offer |-> (in_kind == KIND_OFFER))
    else $error("offer run on a close beat");

endmodule
